[sv/cel_pkg.sv]
// ----------------------------------------------------------------------------
// cel_pkg
// types, constants and log table for the cross entropy loss block
// ----------------------------------------------------------------------------
package cel_pkg;

  localparam int FRAC_BITS  = 15;
  localparam int TBL_BITS   = 8;
  localparam int TBL_N      = 256;
  localparam int ACC_W      = 48;
  localparam int GRAD_W     = 24;
  localparam logic [19:0] LN2_Q20 = 20'd726817;

  typedef struct packed {
    logic [15:0] prediction;
    logic [15:0] truth;
    logic        last_element;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] gradient;
    logic               gradient_saturated;
    logic [31:0]        loss_mean;
    logic               loss_valid;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOG, ST_MUL, ST_GDIV, ST_ACC, ST_MDIV, ST_DONE
  } cel_state_t;

  typedef struct packed {
    logic load;
    logic log_step;
    logic mul_step;
    logic gdiv_start;
    logic gdiv_step;
    logic acc_step;
    logic mdiv_start;
    logic mdiv_step;
    logic emit;
  } cel_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } cel_sts_t;

  // ln(1 + i/256) in Q0.20, built from a truncating 24 bit log2
  function automatic logic [19:0] ln1p_entry(input int i);
    logic [63:0] y;
    logic [63:0] l2;
    logic [95:0] pr;
    l2 = '0;
    if (i >= TBL_N) begin
      l2 = 64'd1 << 24;
    end else begin
      y = (64'd1 << 30) + ((64'(i) << 30) / 64'(TBL_N));
      for (int k = 0; k < 24; k++) begin
        y = (y * y) >> 30;
        l2 = l2 << 1;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          l2 = l2 | 64'd1;
        end
      end
    end
    pr = 96'(l2) * 96'd2977044472 + (96'd1 << 35);
    return pr[55:36];
  endfunction

endpackage

[sv/cel_ctrl.sv]
// ----------------------------------------------------------------------------
// cel_ctrl
// sequencer for log, gradient divide, accumulate and mean divide
// ----------------------------------------------------------------------------
module cel_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cel_pkg::cel_sts_t sts,
  output cel_pkg::cel_cmd_t cmd
);

  cel_pkg::cel_state_t state_r, state_nxt;
  logic                ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cel_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cel_pkg::ST_IDLE: if (in_valid) state_nxt = cel_pkg::ST_LOG;
      cel_pkg::ST_LOG:  state_nxt = cel_pkg::ST_MUL;
      cel_pkg::ST_MUL:  state_nxt = cel_pkg::ST_GDIV;
      cel_pkg::ST_GDIV: if (sts.div_done) state_nxt = cel_pkg::ST_ACC;
      cel_pkg::ST_ACC:  state_nxt = sts.last ? cel_pkg::ST_MDIV : cel_pkg::ST_DONE;
      cel_pkg::ST_MDIV: if (sts.div_done) state_nxt = cel_pkg::ST_DONE;
      cel_pkg::ST_DONE: if (!ovalid_r || !out_stall) state_nxt = cel_pkg::ST_IDLE;
      default:          state_nxt = cel_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    ovalid_nxt = ovalid_r && out_stall;
    case (state_r)
      cel_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      cel_pkg::ST_LOG: cmd.log_step = 1'b1;
      cel_pkg::ST_MUL: begin
        cmd.mul_step   = 1'b1;
        cmd.gdiv_start = 1'b1;
      end
      cel_pkg::ST_GDIV: cmd.gdiv_step = 1'b1;
      cel_pkg::ST_ACC: begin
        cmd.acc_step   = 1'b1;
        cmd.mdiv_start = sts.last;
      end
      cel_pkg::ST_MDIV: cmd.mdiv_step = 1'b1;
      cel_pkg::ST_DONE: begin
        if (!ovalid_r || !out_stall) begin
          cmd.emit   = 1'b1;
          ovalid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ovalid_r;

endmodule

[sv/cel_dp.sv]
// ----------------------------------------------------------------------------
// cel_dp
// log lookup, shared radix-2 divider, loss accumulator and output register
// ----------------------------------------------------------------------------
module cel_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cel_pkg::in_word_t  in_word,
  input  logic [15:0]        cols,
  input  cel_pkg::cel_cmd_t  cmd,
  output cel_pkg::cel_sts_t  sts,
  output cel_pkg::out_word_t out_word
);

  logic [15:0] p_r, t_r;
  logic        last_r;
  logic [3:0]  m_r;
  logic [19:0] lo_r, hi_r;
  logic [31:0] rem_r;
  logic [27:0] nln_r;
  logic [47:0] acc_r, acc_nxt;
  logic [47:0] num_r, quo_r;
  logic [20:0] den_r;
  logic [48:0] prem_r;
  logic [5:0]  cnt_r;
  logic [23:0] grad_r;
  logic        gsat_r;
  cel_pkg::out_word_t ow_r;

  logic [19:0] ln_tab [0:cel_pkg::TBL_N];
  logic [15:0] pc;
  logic [3:0]  msb;
  logic [31:0] f;
  logic [cel_pkg::TBL_BITS:0] idx;
  logic [51:0] interp;
  logic [19:0] frac;
  logic [44:0] term;
  logic [48:0] sum;
  logic [48:0] trial;
  logic [30:0] qg;

  // constant ln(1 + i/256) table with the ln2 endpoint
  for (genvar i = 0; i <= cel_pkg::TBL_N; i++) begin : g_tab
    assign ln_tab[i] = cel_pkg::ln1p_entry(i);
  end

  always_comb begin
    pc = in_word.prediction;
    if (pc == 16'd0) pc = 16'd1;
    if (pc > 16'd32768) pc = 16'd32768;
  end

  always_comb begin
    msb = '0;
    for (int k = 0; k < 16; k++) if (p_r[k]) msb = 4'(k);
  end

  assign f   = 32'(({16'd0, p_r} << (6'd32 - {2'd0, msb})));
  assign idx = {1'b0, f[31:24]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r    <= pc;
      t_r    <= in_word.truth;
      last_r <= in_word.last_element;
    end
    if (cmd.log_step) begin
      m_r   <= msb;
      lo_r  <= ln_tab[idx];
      hi_r  <= ln_tab[idx + 9'd1];
      rem_r <= {f[23:0], 8'd0};
    end
  end

  assign interp = 52'(hi_r - lo_r) * 52'(rem_r);
  assign frac   = lo_r + interp[51:32];

  always_ff @(posedge clk) begin
    if (cmd.mul_step)
      nln_r <= 28'(5'(4'd15 - m_r)) * 28'(cel_pkg::LN2_Q20) - 28'(frac);
  end

  assign term  = 45'((60'(t_r) * 60'(nln_r)) >> cel_pkg::FRAC_BITS);
  assign sum   = {1'b0, acc_r} + 49'(term);
  always_comb begin
    acc_nxt = acc_r;
    if (t_r != 16'd0) acc_nxt = sum[48] ? {48{1'b1}} : sum[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= '0;
    else if (cmd.acc_step) acc_r <= last_r ? 48'd0 : acc_nxt;
  end

  // shared restoring divider, one quotient bit a cycle
  assign trial = {prem_r[47:0], num_r[47]} - {28'd0, den_r};
  always_ff @(posedge clk) begin
    if (cmd.gdiv_start) begin
      num_r  <= {t_r, 32'd0};
      den_r  <= {5'd0, p_r};
      prem_r <= '0;
      quo_r  <= '0;
      cnt_r  <= 6'd31;
    end else if (cmd.mdiv_start) begin
      num_r  <= acc_nxt;
      den_r  <= {1'b0, (cols == 16'd0 ? 16'd1 : cols), 4'd0};
      prem_r <= '0;
      quo_r  <= '0;
      cnt_r  <= 6'd48;
    end else if ((cmd.gdiv_step || cmd.mdiv_step) && cnt_r != 6'd0) begin
      num_r <= num_r << 1;
      cnt_r <= cnt_r - 6'd1;
      if (!trial[48]) begin
        prem_r <= trial;
        quo_r  <= {quo_r[46:0], 1'b1};
      end else begin
        prem_r <= {prem_r[47:0], num_r[47]};
        quo_r  <= {quo_r[46:0], 1'b0};
      end
    end
  end

  assign sts.div_done = (cnt_r == 6'd0);
  assign sts.last     = last_r;
  assign qg           = quo_r[30:0];

  always_ff @(posedge clk) begin
    if (cmd.gdiv_step && cnt_r == 6'd0) begin
      if (t_r == 16'd0) begin
        grad_r <= '0;
        gsat_r <= 1'b0;
      end else if (qg > 31'd8388608) begin
        grad_r <= 24'h800000;
        gsat_r <= 1'b1;
      end else begin
        grad_r <= 24'd0 - qg[23:0];
        gsat_r <= 1'b0;
      end
    end
    if (cmd.emit) begin
      ow_r.gradient           <= grad_r;
      ow_r.gradient_saturated <= gsat_r;
      ow_r.loss_valid         <= last_r;
      ow_r.loss_mean          <= !last_r ? 32'd0 :
                                 (quo_r[47:32] != 16'd0 ? 32'hFFFFFFFF : quo_r[31:0]);
    end
  end

  assign out_word = ow_r;

endmodule

[sv/cross_entropy_loss_and_gradient.sv]
// ----------------------------------------------------------------------------
// cross_entropy_loss_and_gradient
// per-element gradient and batch mean of categorical cross entropy
// ----------------------------------------------------------------------------
//  channel | ports                       | payload
//  in      | in_valid, in_stall          | in_word (prediction, truth, last)
//  out     | out_valid, out_stall        | out_word (gradient, loss)
//  cfg     | cfg_we, cfg_data            | batch column count
//  one word at a time; the last word of a batch also runs the mean divide
//  the shared radix-2 divider paces words: 31 gradient bits, 48 mean bits
//  synchronous reset clears the sum and sets the column count to one
//  a result waits in the output register while out_stall is high
module cross_entropy_loss_and_gradient (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cel_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output cel_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);

  logic [15:0]       cols_r;
  cel_pkg::cel_cmd_t cmd;
  cel_pkg::cel_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) cols_r <= 16'd1;
    else if (cfg_we) cols_r <= cfg_data;
  end

  cel_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts(sts), .cmd(cmd)
  );

  cel_dp u_dp (
    .clk, .rst_n, .in_word, .cols(cols_r), .cmd(cmd), .sts(sts),
    .out_word(out_word)
  );

`ifndef NO_ASSERTIONS
  a_grad_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.gradient[23] || out_word.gradient == 24'd0))
    else $error("positive gradient");
  a_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.loss_valid) |-> out_word.loss_mean == 32'd0)
    else $error("loss without valid");
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.gradient_saturated) |-> out_word.gradient == 24'h800000)
    else $error("saturation value");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams prediction/truth words through the cross entropy block and checks
// every gradient and batch mean against an in-bench fixed-point predictor.
// A directed table covers the field extremes and the special cases, then
// random batches run under random idling, a long output hold-off and a
// drain pause, across several column-count settings.
// ----------------------------------------------------------------------------
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cel_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cel_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  cross_entropy_loss_and_gradient uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int WATCHDOG = 20000;

  logic [19:0] ln_tab [0:256];
  logic [47:0] loss_sum;
  logic [15:0] col_count;
  cel_pkg::out_word_t exp_q[$];
  int errors = 0;
  int idle_pct = 15;
  bit hold_out = 1'b0;
  int quiet = 0;

  typedef struct {
    logic [15:0] p;
    logic [15:0] t;
    logic last;
    bit typed;
    cel_pkg::out_word_t want;
  } row_t;
  row_t rows[$];

  // ln(1 + i/256), truncating 24 bit log2 times ln2
  function automatic logic [19:0] ln_entry(int i);
    logic [63:0] y, l2;
    logic [95:0] pr;
    l2 = '0;
    if (i >= 256) begin
      l2 = 64'd1 << 24;
    end else begin
      y = (64'd1 << 30) + ((64'(i) << 30) >> 8);
      for (int k = 0; k < 24; k++) begin
        y = (y * y) >> 30;
        l2 = l2 << 1;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          l2 = l2 | 64'd1;
        end
      end
    end
    pr = 96'(l2) * 96'd2977044472 + (96'd1 << 35);
    return pr[55:36];
  endfunction

  function automatic logic [63:0] minus_ln(logic [63:0] p);
    int m;
    logic [63:0] f, sc, idx, rem, lo, hi, fr;
    m = 0;
    for (int k = 0; k < 17; k++) if (p[k]) m = k;
    f = (p << (32 - m)) & 64'hFFFF_FFFF;
    sc = f * 256;
    idx = sc >> 32;
    rem = sc & 64'hFFFF_FFFF;
    if (idx >= 256) idx = 255;
    lo = ln_tab[idx];
    hi = ln_tab[idx + 1];
    fr = lo + (((hi - lo) * rem) >> 32);
    return 64'(cel_pkg::FRAC_BITS - m) * 64'd726817 - fr;
  endfunction

  function automatic cel_pkg::out_word_t grad_and_loss(logic [15:0] pin, logic [15:0] t,
                                                       logic last);
    cel_pkg::out_word_t r;
    logic [63:0] p, q, term, mean, cols;
    p = pin;
    q = 0;
    r = '0;
    if (p == 0) p = 1;
    if (p > 32768) p = 32768;
    if (t != 0) begin
      q = (64'(t) << cel_pkg::FRAC_BITS) / p;
      if (q > 8388608) begin
        q = 8388608;
        r.gradient_saturated = 1'b1;
      end
      term = (64'(t) * minus_ln(p)) >> cel_pkg::FRAC_BITS;
      if (term > 64'hFFFF_FFFF_FFFF - loss_sum) loss_sum = '1;
      else loss_sum = loss_sum + term;
    end
    r.gradient = 24'(-q);
    if (last) begin
      cols = (col_count != 0) ? col_count : 1;
      mean = loss_sum / (cols << 4);
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      r.loss_mean = mean[31:0];
      r.loss_valid = 1'b1;
      loss_sum = '0;
    end
    return r;
  endfunction

  task automatic send(logic [15:0] p, logic [15:0] t, logic last);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_word <= '{prediction: p, truth: t, last_element: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_q.push_back(grad_and_loss(p, t, last));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_cols(logic [15:0] v);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    col_count = v;
  endtask

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(9))
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom);
      2: return 16'($urandom_range(32760, 32768));
      default: return 16'($urandom_range(1, 32768));
    endcase
  endfunction

  task automatic random_batches(int n);
    int cnt, len;
    cnt = 0;
    while (cnt < n) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send(rand_prob(), ($urandom_range(3) == 0) ? 16'd0 : rand_prob(), i == len - 1);
        cnt++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_out || (idle_pct > 0 && $urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    cel_pkg::out_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        $display("%0t unexpected word %h", $time, out_word);
        errors++;
      end else begin
        w = exp_q.pop_front();
        if (out_word.gradient !== w.gradient)
          $display("%0t gradient exp %0d got %0d", $time, w.gradient, out_word.gradient);
        if (out_word.gradient_saturated !== w.gradient_saturated)
          $display("%0t saturated exp %b got %b", $time, w.gradient_saturated,
                   out_word.gradient_saturated);
        if (out_word.loss_mean !== w.loss_mean)
          $display("%0t loss_mean exp %h got %h", $time, w.loss_mean, out_word.loss_mean);
        if (out_word.loss_valid !== w.loss_valid)
          $display("%0t loss_valid exp %b got %b", $time, w.loss_valid, out_word.loss_valid);
        if (out_word !== w) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i <= 256; i++) ln_tab[i] = ln_entry(i);
    loss_sum = '0;
    col_count = 16'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // p, t, last, typed, expected
    rows.push_back('{16'd32768, 16'd0, 1'b1, 1'b1,
                     '{gradient: 24'sd0, gradient_saturated: 1'b0,
                       loss_mean: 32'd0, loss_valid: 1'b1}});
    rows.push_back('{16'd32768, 16'd32768, 1'b1, 1'b1,
                     '{gradient: -24'sd32768, gradient_saturated: 1'b0,
                       loss_mean: 32'd0, loss_valid: 1'b1}});
    rows.push_back('{16'd0, 16'd32768, 1'b0, 1'b1,
                     '{gradient: -24'sd8388608, gradient_saturated: 1'b1,
                       loss_mean: 32'd0, loss_valid: 1'b0}});
    rows.push_back('{16'd65535, 16'd32768, 1'b0, 1'b0, '0});
    rows.push_back('{16'd1, 16'd1, 1'b0, 1'b0, '0});
    rows.push_back('{16'd0, 16'd65535, 1'b0, 1'b0, '0});
    rows.push_back('{16'd65535, 16'd65535, 1'b0, 1'b0, '0});
    rows.push_back('{16'd256, 16'd65535, 1'b0, 1'b0, '0});
    rows.push_back('{16'd16384, 16'd16384, 1'b0, 1'b0, '0});
    rows.push_back('{16'd32767, 16'd12345, 1'b0, 1'b0, '0});
    rows.push_back('{16'd3, 16'd0, 1'b1, 1'b0, '0});
    rows.push_back('{16'd21845, 16'd10922, 1'b1, 1'b0, '0});
    foreach (rows[i]) begin
      send(rows[i].p, rows[i].t, rows[i].last);
      if (rows[i].typed && exp_q[$] !== rows[i].want) begin
        $display("%0t table row %0d exp %h pred %h", $time, i, rows[i].want, exp_q[$]);
        errors++;
      end
    end
    drain();

    set_cols(16'd0);
    for (int i = 0; i < 40; i++) send(16'd1, 16'hFFFF, i == 39);
    drain();
    set_cols(16'hFFFF);
    for (int i = 0; i < 6; i++) send(16'd2, 16'hFFFF, i == 5);
    drain();

    set_cols(16'd3);
    random_batches(120);
    // long output hold-off while words keep coming
    fork
      begin
        hold_out = 1'b1;
        repeat (400) @(posedge clk);
        hold_out = 1'b0;
      end
      random_batches(10);
    join
    drain();

    set_cols(16'($urandom_range(1, 65535)));
    idle_pct = 0;
    random_batches(100);
    idle_pct = 15;
    drain();
    set_cols(16'd1);
    random_batches(150);
    drain();
    set_cols(16'($urandom_range(2, 300)));
    random_batches(120);
    drain();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
